[hdl/sotff_pkg.sv]
package sotff_pkg;

   // item kinds on req_func
   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_DONE = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   localparam int FIFO_FRAMES_DEFAULT = 1024;
   localparam int SAMPLE_W            = 16;
   localparam int FRAMES_HELD_W       = 11;
   localparam int LOST_W              = 4;

   localparam logic [LOST_W-1:0]   LOST_MAX       = 4'd15;
   localparam logic [SAMPLE_W-1:0] LOST_MARK      = 16'hFFFF;
   localparam logic [SAMPLE_W-1:0] LOW_BITS_CLEAR = 16'hFFFC;

   typedef struct packed {
      logic [SAMPLE_W-1:0] current;
      logic [SAMPLE_W-1:0] voltage;
   } frame_type;

endpackage

[hdl/sampler_overrun_tagging_frame_fifo.sv]
// Timing: a tick, a completion or a read of an empty FIFO gives its word in the cycle
// after acceptance; a read that pops a frame gives it through the registered read
// port of the frame store and the result register. Throughput: one item per cycle
// while no result word stalls; a frame pop holds off new items while it is read.
// Reset: synchronous, active high; clears busy, lost count, pointers and frame count.
// The frame store is not cleared; no entry is read before it is written.
module sampler_overrun_tagging_frame_fifo #(
   parameter int FIFO_FRAMES = sotff_pkg::FIFO_FRAMES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_func,
   input  logic                                  req_start_failed,
   input  logic [sotff_pkg::SAMPLE_W-1:0]        req_voltage_in,
   input  logic [sotff_pkg::SAMPLE_W-1:0]        req_current_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_trigger,
   output logic                                  rsp_frame_valid,
   output logic [sotff_pkg::SAMPLE_W-1:0]        rsp_voltage_out,
   output logic [sotff_pkg::SAMPLE_W-1:0]        rsp_current_out,
   output logic [sotff_pkg::FRAMES_HELD_W-1:0]   rsp_frames_held,
   output logic                                  rsp_dropped_oldest
);
   import sotff_pkg::*;

   localparam int PW = $clog2(FIFO_FRAMES);
   localparam int CW = $clog2(FIFO_FRAMES + 1);

   typedef enum logic {ST_IDLE, ST_READ} state_type;

   state_type              state_ff, state_in;
   logic                   busy_ff, busy_in;
   logic [LOST_W-1:0]      lost_ff, lost_in;
   logic [PW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW+FRAMES_HELD_W-1:0] count_wide;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_trigger_ff, rsp_trigger_in;
   logic                   rsp_frame_valid_ff, rsp_frame_valid_in;
   logic [SAMPLE_W-1:0]    rsp_voltage_ff, rsp_voltage_in;
   logic [SAMPLE_W-1:0]    rsp_current_ff, rsp_current_in;
   logic [FRAMES_HELD_W-1:0] rsp_held_ff, rsp_held_in;
   logic                   rsp_dropped_ff, rsp_dropped_in;

   logic                   accept;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   frame_type              ram_wr_data;
   frame_type              ram_rd_data;
   logic [SAMPLE_W-1:0]    volt_masked;
   logic [SAMPLE_W-1:0]    curr_masked;

   function automatic logic [PW-1:0] next_index(input logic [PW-1:0] p);
      if (p == PW'(FIFO_FRAMES - 1)) begin
         return '0;
      end
      return p + PW'(1);
   endfunction

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign volt_masked = req_voltage_in & LOW_BITS_CLEAR;
   assign curr_masked = req_current_in & LOW_BITS_CLEAR;
   assign count_wide  = {{FRAMES_HELD_W{1'b0}}, count_in};

   always_comb begin
      state_in           = state_ff;
      busy_in            = busy_ff;
      lost_in            = lost_ff;
      wr_ptr_in          = wr_ptr_ff;
      rd_ptr_in          = rd_ptr_ff;
      count_in           = count_ff;
      // drop the waiting word once it is taken
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_trigger_in     = rsp_trigger_ff;
      rsp_frame_valid_in = rsp_frame_valid_ff;
      rsp_voltage_in     = rsp_voltage_ff;
      rsp_current_in     = rsp_current_ff;
      rsp_held_in        = rsp_held_ff;
      rsp_dropped_in     = rsp_dropped_ff;
      ram_wr_en          = 1'b0;
      ram_rd_en          = 1'b0;
      ram_wr_data.voltage = LOST_MARK;
      ram_wr_data.current = LOST_MARK;

      if (state_ff == ST_READ) begin
         // popped frame arrives from the store; pointers already advanced
         state_in           = ST_IDLE;
         rsp_valid_in       = 1'b1;
         rsp_trigger_in     = busy_ff;
         rsp_frame_valid_in = 1'b1;
         rsp_voltage_in     = ram_rd_data.voltage;
         rsp_current_in     = ram_rd_data.current;
         rsp_held_in        = count_wide[FRAMES_HELD_W-1:0];
         rsp_dropped_in     = 1'b0;
      end else if (accept) begin
         rsp_frame_valid_in = 1'b0;
         rsp_voltage_in     = '0;
         rsp_current_in     = '0;
         rsp_dropped_in     = 1'b0;
         rsp_valid_in       = 1'b1;
         case (req_func)
            FUNC_TICK: begin
               if (busy_ff) begin
                  if (lost_ff != LOST_MAX) begin
                     lost_in = lost_ff + LOST_W'(1);
                  end
               end else begin
                  busy_in = !req_start_failed;
               end
            end
            FUNC_DONE: begin
               if (lost_ff == '0) begin
                  ram_wr_data.voltage = volt_masked;
                  ram_wr_data.current = curr_masked;
               end
               ram_wr_en = 1'b1;
               lost_in   = '0;
               busy_in   = 1'b0;
               wr_ptr_in = next_index(wr_ptr_ff);
               // full: advance past the oldest frame, count stays
               if (count_ff == CW'(FIFO_FRAMES)) begin
                  rd_ptr_in      = next_index(rd_ptr_ff);
                  rsp_dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            FUNC_READ: begin
               if (count_ff != '0) begin
                  ram_rd_en    = 1'b1;
                  rd_ptr_in    = next_index(rd_ptr_ff);
                  count_in     = count_ff - CW'(1);
                  rsp_valid_in = 1'b0;
                  state_in     = ST_READ;
               end
            end
            default: begin
            end
         endcase
         rsp_trigger_in = busy_in;
         rsp_held_in    = count_wide[FRAMES_HELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         lost_ff      <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         lost_ff      <= lost_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_trigger_ff     <= rsp_trigger_in;
      rsp_frame_valid_ff <= rsp_frame_valid_in;
      rsp_voltage_ff     <= rsp_voltage_in;
      rsp_current_ff     <= rsp_current_in;
      rsp_held_ff        <= rsp_held_in;
      rsp_dropped_ff     <= rsp_dropped_in;
   end

   sotff_frame_ram #(
      .DEPTH (FIFO_FRAMES),
      .AW    (PW)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_trigger        = rsp_trigger_ff;
   assign rsp_frame_valid    = rsp_frame_valid_ff;
   assign rsp_voltage_out    = rsp_voltage_ff;
   assign rsp_current_out    = rsp_current_ff;
   assign rsp_frames_held    = rsp_held_ff;
   assign rsp_dropped_oldest = rsp_dropped_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(FIFO_FRAMES))
      else $error("frame count exceeds FIFO depth");

   a_lost_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (lost_ff != '0) |-> busy_ff)
      else $error("lost periods counted while no conversion is busy");

   a_read_no_pending_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("frame pop overlaps a waiting result word");

   a_trigger_tracks_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_trigger_ff == busy_ff))
      else $error("trigger in result word differs from busy");

   a_done_fills: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == FUNC_DONE)) |=> (count_ff != '0))
      else $error("completion left the FIFO empty");

endmodule

[hdl/sotff_frame_ram.sv]
module sotff_frame_ram #(
   parameter int DEPTH = sotff_pkg::FIFO_FRAMES_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  sotff_pkg::frame_type wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output sotff_pkg::frame_type rd_data
);
   import sotff_pkg::*;

   frame_type mem [DEPTH];
   frame_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
